>>> hdl/dwsc_pkg.sv
// ----------------------------------------------------------------------------
// dwsc_pkg
// Shared types and constants for the dual wheel speed capture core.
// ----------------------------------------------------------------------------
package dwsc_pkg;

    localparam int NUM_CHANNELS  = 2;
    localparam int COUNTER_BITS  = 16;
    localparam int CH_W          = 1;
    localparam int WRAP_W        = 16;
    localparam int TICK_W        = 32;
    localparam int SUM_W         = TICK_W + 1;
    localparam int SUB_W         = SUM_W + 1;
    localparam int QUOT_W        = 32;
    localparam int STEP_W        = $clog2(QUOT_W);
    localparam int CFG_INDEX_W   = 1;

    localparam logic [STEP_W-1:0] LAST_STEP     = STEP_W'(QUOT_W - 1);
    localparam logic [WRAP_W-1:0] WRAP_MAX      = '1;
    localparam logic [TICK_W-1:0] SCALE_RESET   = 32'd6000000;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1171;

    typedef enum logic [1:0] {
        REQ_WRAP    = 2'd0,
        REQ_CAPTURE = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_TIMEOUT = 2'd3
    } req_type_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPEED_SCALE   = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOAD   = 2'd1,
        ST_APPLY  = 2'd2,
        ST_DIVIDE = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [CH_W-1:0]         channel;
        logic [COUNTER_BITS-1:0] count_value;
    } cmd_t;

    typedef struct packed {
        logic [QUOT_W-1:0] speed_q8;
        logic              new_measurement;
        logic              timed_out;
    } result_t;

endpackage

>>> hdl/dual_wheel_speed_capture_core.sv
// ----------------------------------------------------------------------------
// dual_wheel_speed_capture_core
// Two-channel wheel speed meter driven by capture counter events.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off. A
// counter wrap, or a speed query with an empty half period, is answered from
// the load state; a capture edge or timeout check goes on through the apply
// state; a speed query with both half periods set runs after the load state
// through the 32-step restoring divider that runs on the block's single shared
// subtractor (the same unit also forms elapsed ticks and the timeout compare).
// Configuration writes are always ready and take effect at once.
module dual_wheel_speed_capture_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dwsc_pkg::cmd_t                      cmd,
    output logic                                done,
    output dwsc_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dwsc_pkg::TICK_W-1:0]         cfg_data
);

    dwsc_pkg::state_t                     state_reg, state_next;
    dwsc_pkg::cmd_t                       cmd_reg, cmd_next;
    dwsc_pkg::result_t                    result_reg, result_next;
    logic                                 done_reg, done_next;
    logic [dwsc_pkg::TICK_W-1:0]          scale_reg, timeout_reg;

    logic [dwsc_pkg::COUNTER_BITS-1:0]    last_reg   [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::COUNTER_BITS-1:0]    last_next  [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::WRAP_W-1:0]          wrap_reg   [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::WRAP_W-1:0]          wrap_next  [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::TICK_W-1:0]          half0_reg  [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::TICK_W-1:0]          half0_next [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::TICK_W-1:0]          half1_reg  [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::TICK_W-1:0]          half1_next [dwsc_pkg::NUM_CHANNELS];
    logic [dwsc_pkg::NUM_CHANNELS-1:0]    phase_reg, phase_next;
    logic [dwsc_pkg::NUM_CHANNELS-1:0]    fresh_reg, fresh_next;

    logic [dwsc_pkg::TICK_W-1:0]          elapsed_reg, elapsed_next;
    logic [dwsc_pkg::SUM_W-1:0]           divisor_reg, divisor_next;
    logic [dwsc_pkg::SUM_W-1:0]           rem_reg, rem_next;
    logic [dwsc_pkg::QUOT_W-1:0]          quot_reg, quot_next;
    logic [dwsc_pkg::STEP_W-1:0]          step_reg, step_next;

    logic [dwsc_pkg::SUB_W-1:0]           sub_a, sub_b;
    logic [dwsc_pkg::SUB_W:0]             sub_diff;
    logic                                 sub_borrow;
    logic [dwsc_pkg::CH_W-1:0]            ch;
    logic                                 halves_set;

    assign ch         = cmd_reg.channel;
    assign halves_set = (half0_reg[ch] != '0) && (half1_reg[ch] != '0);
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[dwsc_pkg::SUB_W];

    assign busy      = (state_reg != dwsc_pkg::ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dwsc_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = dwsc_pkg::ST_LOAD;
            end
            dwsc_pkg::ST_LOAD:
            begin
                case (cmd_reg.req_type)
                    dwsc_pkg::REQ_WRAP:
                        state_next = dwsc_pkg::ST_IDLE;
                    dwsc_pkg::REQ_QUERY:
                        state_next = halves_set ? dwsc_pkg::ST_DIVIDE : dwsc_pkg::ST_IDLE;
                    default:
                        state_next = dwsc_pkg::ST_APPLY;
                endcase
            end
            dwsc_pkg::ST_APPLY:
                state_next = dwsc_pkg::ST_IDLE;
            dwsc_pkg::ST_DIVIDE:
            begin
                if (step_reg == dwsc_pkg::LAST_STEP)
                    state_next = dwsc_pkg::ST_IDLE;
            end
            default:
                state_next = dwsc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        last_next    = last_reg;
        wrap_next    = wrap_reg;
        half0_next   = half0_reg;
        half1_next   = half1_reg;
        phase_next   = phase_reg;
        fresh_next   = fresh_reg;
        elapsed_next = elapsed_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        sub_a        = '0;
        sub_b        = '0;

        case (state_reg)
            dwsc_pkg::ST_IDLE:
            begin
                if (start)
                    cmd_next = cmd;
            end
            dwsc_pkg::ST_LOAD:
            begin
                sub_a = {2'b00, wrap_reg[ch], cmd_reg.count_value};
                sub_b = dwsc_pkg::SUB_W'(last_reg[ch]);
                if (wrap_reg[ch] == '0)
                    elapsed_next = dwsc_pkg::TICK_W'(sub_diff[dwsc_pkg::COUNTER_BITS-1:0]);
                else
                    elapsed_next = sub_diff[dwsc_pkg::TICK_W-1:0];
                case (cmd_reg.req_type)
                    dwsc_pkg::REQ_WRAP:
                    begin
                        for (int i = 0; i < dwsc_pkg::NUM_CHANNELS; i++)
                        begin
                            if (wrap_reg[i] != dwsc_pkg::WRAP_MAX)
                                wrap_next[i] = wrap_reg[i] + 1'b1;
                        end
                        done_next   = 1'b1;
                        result_next = '{speed_q8: '0, new_measurement: fresh_reg[ch],
                                        timed_out: 1'b0};
                    end
                    dwsc_pkg::REQ_QUERY:
                    begin
                        fresh_next[ch] = 1'b0;
                        divisor_next   = {1'b0, half0_reg[ch]} + {1'b0, half1_reg[ch]};
                        rem_next       = '0;
                        quot_next      = scale_reg;
                        step_next      = '0;
                        if (!halves_set)
                        begin
                            done_next   = 1'b1;
                            result_next = '{speed_q8: '0, new_measurement: 1'b0,
                                            timed_out: 1'b0};
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            dwsc_pkg::ST_APPLY:
            begin
                sub_a     = dwsc_pkg::SUB_W'(timeout_reg);
                sub_b     = dwsc_pkg::SUB_W'(elapsed_reg);
                done_next = 1'b1;
                if (cmd_reg.req_type == dwsc_pkg::REQ_CAPTURE)
                begin
                    if (phase_reg[ch])
                        half1_next[ch] = elapsed_reg;
                    else
                        half0_next[ch] = elapsed_reg;
                    wrap_next[ch]  = '0;
                    last_next[ch]  = cmd_reg.count_value;
                    phase_next[ch] = ~phase_reg[ch];
                    fresh_next[ch] = 1'b1;
                    result_next    = '{speed_q8: '0, new_measurement: 1'b1,
                                       timed_out: 1'b0};
                end
                else if (sub_borrow)
                begin
                    half0_next[ch] = '0;
                    half1_next[ch] = '0;
                    fresh_next[ch] = 1'b1;
                    result_next    = '{speed_q8: '0, new_measurement: 1'b1,
                                       timed_out: 1'b1};
                end
                else
                begin
                    result_next = '{speed_q8: '0, new_measurement: fresh_reg[ch],
                                    timed_out: 1'b0};
                end
            end
            dwsc_pkg::ST_DIVIDE:
            begin
                sub_a     = {rem_reg, quot_reg[dwsc_pkg::QUOT_W-1]};
                sub_b     = {1'b0, divisor_reg};
                quot_next = {quot_reg[dwsc_pkg::QUOT_W-2:0], ~sub_borrow};
                if (sub_borrow)
                    rem_next = sub_a[dwsc_pkg::SUM_W-1:0];
                else
                    rem_next = sub_diff[dwsc_pkg::SUM_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == dwsc_pkg::LAST_STEP)
                begin
                    done_next   = 1'b1;
                    result_next = '{speed_q8: quot_next, new_measurement: 1'b0,
                                    timed_out: 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dwsc_pkg::ST_IDLE;
            done_reg    <= 1'b0;
            scale_reg   <= dwsc_pkg::SCALE_RESET;
            timeout_reg <= dwsc_pkg::TIMEOUT_RESET;
            phase_reg   <= '0;
            fresh_reg   <= '0;
            step_reg    <= '0;
            for (int i = 0; i < dwsc_pkg::NUM_CHANNELS; i++)
            begin
                last_reg[i]  <= '0;
                wrap_reg[i]  <= '0;
                half0_reg[i] <= '0;
                half1_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            fresh_reg <= fresh_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            wrap_reg  <= wrap_next;
            half0_reg <= half0_next;
            half1_reg <= half1_next;
            if (cfg_valid && cfg_ready)
            begin
                case (dwsc_pkg::cfg_index_t'(cfg_index))
                    dwsc_pkg::CFG_SPEED_SCALE:   scale_reg   <= cfg_data;
                    dwsc_pkg::CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        result_reg  <= result_next;
        elapsed_reg <= elapsed_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
    end

endmodule
